// ===== hdl/wgs_pkg.sv =====
`timescale 1ns / 1ps

package wgs_pkg;

    // Store geometry
    localparam int MAX_VERTICES = 64;
    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int CW     = $clog2(MAX_VERTICES + 1);
    localparam int CMPW   = (CW > 7) ? CW : 7;
    localparam int EAW    = 2 * VW;
    localparam int EDEPTH = 1 << EAW;
    localparam int EWID   = 33;

    localparam logic signed [31:0] MISS_WORD = 32'sh8000_0000;

    typedef enum logic [3:0] {
        OP_ADD_V   = 4'd0,
        OP_SET_V   = 4'd1,
        OP_GET_V   = 4'd2,
        OP_ERASE_V = 4'd3,
        OP_ADD_E   = 4'd4,
        OP_SET_E   = 4'd5,
        OP_GET_E   = 4'd6,
        OP_ERASE_E = 4'd7,
        OP_CLEAR   = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_FULL   = 2'd2
    } stat_t;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [5:0]         src_vertex;
        logic [5:0]         dst_vertex;
        logic signed [31:0] data_in;
    } req_t;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
        logic [6:0]         vertex_count;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EDGE_CHK,
        S_VERT_RD,
        S_ADD_CLR,
        S_CMP_RD,
        S_CMP_WR,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] { VW_SRC, VW_NEW, VW_CMP } vwsel_t;
    typedef enum logic       { VR_SRC, VR_CMP } vrsel_t;
    typedef enum logic [1:0] { EW_SET, EW_ERASE, EW_CLR, EW_CMP } ewsel_t;
    typedef enum logic       { ER_REQ, ER_CMP } ersel_t;
    typedef enum logic [1:0] { TOT_KEEP, TOT_INC, TOT_DEC, TOT_ZERO } tot_t;
    typedef enum logic [1:0] { RD_MISS, RD_VERT, RD_EDGE } rdsel_t;

    // Controller -> datapath
    typedef struct packed {
        logic   req_load;
        logic   v_we;
        vwsel_t v_wsel;
        logic   v_re;
        vrsel_t v_rsel;
        logic   e_we;
        ewsel_t e_wsel;
        logic   e_re;
        ersel_t e_rsel;
        logic   add_init;
        logic   add_step;
        logic   cmp_init;
        logic   cmp_step;
        tot_t   tot_op;
        logic   res_load;
        stat_t  res_status;
        rdsel_t res_sel;
        logic   out_load;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [3:0] opcode;
        logic       full;
        logic       src_ok;
        logic       edge_ok;
        logic       e_present;
        logic       add_last;
        logic       cmp_last;
        logic       cmp_single;
        logic       cmp_jzero;
        logic       out_free;
    } flags_t;

    function automatic logic [CMPW-1:0] to_cmp(input logic [5:0] x);
        return CMPW'(x);
    endfunction

    function automatic logic [VW-1:0] to_idx(input logic [5:0] x);
        logic [CMPW-1:0] t;
        t = CMPW'(x);
        return t[VW-1:0];
    endfunction

endpackage

// ===== hdl/weighted_graph_store.sv =====
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// request  req_valid / req_ready  req (req_t: opcode, src_vertex, dst_vertex, data_in)
// response rsp_valid / rsp_ready  rsp (rsp_t: data_out, status, vertex_count)
//
// One request at a time; once the response is staged, the controller goes back to idle to accept.
// Vertex/edge ops make at most one memory round trip. Clear only resets the vertex count.
// Add vertex clears the new row and column one cell a cycle.
// Erase vertex, for N > 1 vertices (the last one is simply dropped), copies each of the (N-1)^2
// kept edge cells through the edge RAM's single read and write ports.
// Reset empties the store at once; no clearing pass. A new request is taken while the
// previous response waits; a stalled response holds the controller in its last state.

module weighted_graph_store import wgs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t   cmd;
    flags_t flags;

    wgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    wgs_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .flags     (flags),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== hdl/wgs_ram.sv =====
`timescale 1ns / 1ps

module wgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/wgs_ctrl.sv =====
`timescale 1ns / 1ps

module wgs_ctrl import wgs_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    input  flags_t flags,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        req_ready  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = STAT_REJECT;
                cmd.res_sel    = RD_MISS;
                state_next     = S_FINISH;
                case (flags.opcode)
                    OP_ADD_V:
                    begin
                        if (flags.full)
                        begin
                            cmd.res_status = STAT_FULL;
                        end
                        else
                        begin
                            cmd.res_load = 1'b0;
                            cmd.v_we     = 1'b1;
                            cmd.v_wsel   = VW_NEW;
                            cmd.add_init = 1'b1;
                            state_next   = S_ADD_CLR;
                        end
                    end
                    OP_SET_V:
                    begin
                        if (flags.src_ok)
                        begin
                            cmd.v_we       = 1'b1;
                            cmd.v_wsel     = VW_SRC;
                            cmd.res_status = STAT_OK;
                        end
                    end
                    OP_GET_V:
                    begin
                        if (flags.src_ok)
                        begin
                            cmd.res_load = 1'b0;
                            cmd.v_re     = 1'b1;
                            cmd.v_rsel   = VR_SRC;
                            state_next   = S_VERT_RD;
                        end
                    end
                    OP_ERASE_V:
                    begin
                        if (flags.src_ok)
                        begin
                            if (flags.cmp_single)
                            begin
                                cmd.tot_op     = TOT_DEC;
                                cmd.res_status = STAT_OK;
                            end
                            else
                            begin
                                cmd.res_load = 1'b0;
                                cmd.cmp_init = 1'b1;
                                state_next   = S_CMP_RD;
                            end
                        end
                    end
                    OP_ADD_E:
                    begin
                        if (flags.edge_ok)
                        begin
                            cmd.e_we       = 1'b1;
                            cmd.e_wsel     = EW_SET;
                            cmd.res_status = STAT_OK;
                        end
                    end
                    OP_SET_E, OP_GET_E, OP_ERASE_E:
                    begin
                        if (flags.edge_ok)
                        begin
                            cmd.res_load = 1'b0;
                            cmd.e_re     = 1'b1;
                            cmd.e_rsel   = ER_REQ;
                            state_next   = S_EDGE_CHK;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.tot_op     = TOT_ZERO;
                        cmd.res_status = STAT_OK;
                    end
                    default:
                    begin
                        cmd.res_status = STAT_REJECT;
                    end
                endcase
            end
            S_EDGE_CHK:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = STAT_REJECT;
                cmd.res_sel    = RD_MISS;
                if (flags.e_present)
                begin
                    cmd.res_status = STAT_OK;
                    case (flags.opcode)
                        OP_SET_E:
                        begin
                            cmd.e_we   = 1'b1;
                            cmd.e_wsel = EW_SET;
                        end
                        OP_GET_E:
                        begin
                            cmd.res_sel = RD_EDGE;
                        end
                        default:
                        begin
                            cmd.e_we   = 1'b1;
                            cmd.e_wsel = EW_ERASE;
                        end
                    endcase
                end
                state_next = S_FINISH;
            end
            S_VERT_RD:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = STAT_OK;
                cmd.res_sel    = RD_VERT;
                state_next     = S_FINISH;
            end
            S_ADD_CLR:
            begin
                // clear the new vertex's row and column, one cell a cycle
                cmd.e_we     = 1'b1;
                cmd.e_wsel   = EW_CLR;
                cmd.add_step = 1'b1;
                if (flags.add_last)
                begin
                    cmd.tot_op     = TOT_INC;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STAT_OK;
                    cmd.res_sel    = RD_MISS;
                    state_next     = S_FINISH;
                end
            end
            S_CMP_RD:
            begin
                cmd.e_re   = 1'b1;
                cmd.e_rsel = ER_CMP;
                cmd.v_re   = 1'b1;
                cmd.v_rsel = VR_CMP;
                state_next = S_CMP_WR;
            end
            S_CMP_WR:
            begin
                cmd.e_we     = 1'b1;
                cmd.e_wsel   = EW_CMP;
                cmd.v_we     = flags.cmp_jzero;
                cmd.v_wsel   = VW_CMP;
                cmd.cmp_step = 1'b1;
                if (flags.cmp_last)
                begin
                    cmd.tot_op     = TOT_DEC;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STAT_OK;
                    cmd.res_sel    = RD_MISS;
                    state_next     = S_FINISH;
                end
                else
                begin
                    state_next = S_CMP_RD;
                end
            end
            S_FINISH:
            begin
                if (flags.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/wgs_dpath.sv =====
`timescale 1ns / 1ps

module wgs_dpath import wgs_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  req_t   req,
    input  cmd_t   cmd,
    output flags_t flags,
    output logic   rsp_valid,
    input  logic   rsp_ready,
    output rsp_t   rsp
);

    req_t               req_reg;
    logic [CW-1:0]      total_reg;
    logic [CW-1:0]      total_next;
    logic [VW:0]        add_reg;
    logic [VW-1:0]      ci_reg;
    logic [VW-1:0]      cj_reg;
    logic signed [31:0] res_data_reg;
    logic [1:0]         res_status_reg;
    logic               out_valid_reg;
    rsp_t               out_reg;

    logic [VW-1:0]      src_idx;
    logic [VW-1:0]      dst_idx;
    logic [VW-1:0]      new_idx;
    logic [VW-1:0]      add_k;
    logic [VW-1:0]      lim;
    logic [CW-1:0]      tm2;
    logic [VW-1:0]      oi;
    logic [VW-1:0]      oj;
    logic [CMPW-1:0]    total_ext;
    logic               src_ok;
    logic               dst_ok;

    logic               v_we;
    logic [VW-1:0]      v_waddr;
    logic [31:0]        v_wdata;
    logic [VW-1:0]      v_raddr;
    logic [31:0]        v_rdata;
    logic [EAW-1:0]     e_waddr;
    logic [EWID-1:0]    e_wdata;
    logic [EAW-1:0]     e_raddr;
    logic [EWID-1:0]    e_rdata;

    // Request latch
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_reg <= req;
        end
    end

    assign src_idx   = to_idx(req_reg.src_vertex);
    assign dst_idx   = to_idx(req_reg.dst_vertex);
    assign new_idx   = total_reg[VW-1:0];
    assign total_ext = CMPW'(total_reg);
    assign src_ok    = to_cmp(req_reg.src_vertex) < total_ext;
    assign dst_ok    = to_cmp(req_reg.dst_vertex) < total_ext;
    assign add_k     = add_reg[VW:1];
    assign tm2       = total_reg - CW'(2);
    assign lim       = tm2[VW-1:0];

    // Compaction source skips the erased vertex
    assign oi = (ci_reg < src_idx) ? ci_reg : ci_reg + VW'(1);
    assign oj = (cj_reg < src_idx) ? cj_reg : cj_reg + VW'(1);

    // Status to controller
    always_comb
    begin
        flags            = '0;
        flags.opcode     = req_reg.opcode;
        flags.full       = total_reg == CW'(MAX_VERTICES);
        flags.src_ok     = src_ok;
        flags.edge_ok    = src_ok && dst_ok && (req_reg.src_vertex != req_reg.dst_vertex);
        flags.e_present  = e_rdata[EWID-1];
        flags.add_last   = add_reg == {VW'(MAX_VERTICES - 1), 1'b1};
        flags.cmp_last   = (ci_reg == lim) && (cj_reg == lim);
        flags.cmp_single = total_reg == CW'(1);
        flags.cmp_jzero  = cj_reg == '0;
        flags.out_free   = !out_valid_reg || rsp_ready;
    end

    // Walk counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_reg <= '0;
            ci_reg  <= '0;
            cj_reg  <= '0;
        end
        else
        begin
            if (cmd.add_init)
            begin
                add_reg <= '0;
            end
            else if (cmd.add_step)
            begin
                add_reg <= add_reg + (VW+1)'(1);
            end
            if (cmd.cmp_init)
            begin
                ci_reg <= '0;
                cj_reg <= '0;
            end
            else if (cmd.cmp_step)
            begin
                if (cj_reg == lim)
                begin
                    cj_reg <= '0;
                    ci_reg <= ci_reg + VW'(1);
                end
                else
                begin
                    cj_reg <= cj_reg + VW'(1);
                end
            end
        end
    end

    // Vertex count
    always_comb
    begin
        case (cmd.tot_op)
            TOT_INC:  total_next = total_reg + CW'(1);
            TOT_DEC:  total_next = total_reg - CW'(1);
            TOT_ZERO: total_next = '0;
            default:  total_next = total_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    // Vertex memory ports
    always_comb
    begin
        v_we = cmd.v_we;
        case (cmd.v_wsel)
            VW_NEW:  v_waddr = new_idx;
            VW_CMP:  v_waddr = ci_reg;
            default: v_waddr = src_idx;
        endcase
        v_wdata = (cmd.v_wsel == VW_CMP) ? v_rdata : req_reg.data_in;
        v_raddr = (cmd.v_rsel == VR_CMP) ? oi : src_idx;
    end

    // Edge memory ports: {present, weight} at {src, dst}
    always_comb
    begin
        case (cmd.e_wsel)
            EW_ERASE:
            begin
                e_waddr = {src_idx, dst_idx};
                e_wdata = {1'b0, e_rdata[31:0]};
            end
            EW_CLR:
            begin
                e_waddr = add_reg[0] ? {add_k, new_idx} : {new_idx, add_k};
                e_wdata = '0;
            end
            EW_CMP:
            begin
                e_waddr = {ci_reg, cj_reg};
                e_wdata = e_rdata;
            end
            default:
            begin
                e_waddr = {src_idx, dst_idx};
                e_wdata = {1'b1, req_reg.data_in};
            end
        endcase
        e_raddr = (cmd.e_rsel == ER_CMP) ? {oi, oj} : {src_idx, dst_idx};
    end

    wgs_ram #(
        .WIDTH (32),
        .DEPTH (MAX_VERTICES)
    ) u_vram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (cmd.v_re),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    wgs_ram #(
        .WIDTH (EWID),
        .DEPTH (EDEPTH)
    ) u_eram (
        .clk   (clk),
        .we    (cmd.e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .re    (cmd.e_re),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    // Result staging
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            case (cmd.res_sel)
                RD_VERT: res_data_reg <= v_rdata;
                RD_EDGE: res_data_reg <= e_rdata[31:0];
                default: res_data_reg <= MISS_WORD;
            endcase
        end
        if (cmd.out_load)
        begin
            out_reg.data_out     <= res_data_reg;
            out_reg.status       <= res_status_reg;
            out_reg.vertex_count <= total_ext[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Checks
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(MAX_VERTICES))
        else $error("vertex count above capacity");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || rsp_ready))
        else $error("response overwritten before taken");

    a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tot_op == TOT_INC) |-> (total_reg < CW'(MAX_VERTICES)))
        else $error("vertex added to full store");

    a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tot_op == TOT_DEC) |-> (total_reg != '0))
        else $error("vertex erased from empty store");

endmodule
